[hdl/nsem_pkg.sv]
`timescale 1ns / 1ps

package nsem_pkg;

  localparam int KEY_W   = 64;
  localparam int INIT_W  = 15;
  localparam int COUNT_W = 16;
  localparam int USERS_W = 8;

  typedef enum logic [1:0] {
    ACT_OPEN  = 2'd0,
    ACT_CLOSE = 2'd1,
    ACT_WAIT  = 2'd2,
    ACT_POST  = 2'd3
  } nsem_action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } nsem_status_t;

  localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
  localparam logic [USERS_W-1:0]        USERS_MAX = {USERS_W{1'b1}};

  typedef struct packed {
    nsem_action_t      action;
    logic [KEY_W-1:0]  key;
    logic [INIT_W-1:0] start_value;
  } nsem_req_t;

  typedef struct packed {
    nsem_status_t               status;
    logic                       block;
    logic                       wake;
    logic signed [COUNT_W-1:0]  count;
  } nsem_rsp_t;

  // Search token that walks the row of slot cells, one cell per cycle.
  typedef struct packed {
    logic                       valid;
    nsem_action_t               action;
    logic [KEY_W-1:0]           key;
    logic [INIT_W-1:0]          start_value;
    logic                       found;
    logic                       free_found;
    logic signed [COUNT_W-1:0]  count;
    logic [USERS_W-1:0]         users;
  } nsem_tok_t;

  // Slot write broadcast to every cell; the cell whose index matches takes it.
  typedef struct packed {
    logic                       en;
    logic                       used;
    logic [KEY_W-1:0]           key;
    logic signed [COUNT_W-1:0]  count;
    logic [USERS_W-1:0]         users;
  } nsem_wr_t;

endpackage

[hdl/nsem_cell.sv]
`timescale 1ns / 1ps

module nsem_cell #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  nsem_pkg::nsem_tok_t tok_in,
  input  logic [IDX_W-1:0]    found_idx_in,
  input  logic [IDX_W-1:0]    free_idx_in,
  output nsem_pkg::nsem_tok_t tok_out,
  output logic [IDX_W-1:0]    found_idx_out,
  output logic [IDX_W-1:0]    free_idx_out,
  input  nsem_pkg::nsem_wr_t  wr,
  input  logic [IDX_W-1:0]    wr_idx
);
  import nsem_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                      used;
  logic [KEY_W-1:0]          key;
  logic signed [COUNT_W-1:0] count;
  logic [USERS_W-1:0]        users;

  nsem_tok_t         tok_next;
  logic [IDX_W-1:0]  found_idx_next;
  logic [IDX_W-1:0]  free_idx_next;
  logic              wr_hit;

  assign wr_hit = wr.en && (wr_idx == MY_IDX);

  always_comb begin
    tok_next       = tok_in;
    found_idx_next = found_idx_in;
    free_idx_next  = free_idx_in;
    // The first used slot holding the key wins; the first free slot is noted for open.
    if (used && (key == tok_in.key) && !tok_in.found) begin
      tok_next.found = 1'b1;
      tok_next.count = count;
      tok_next.users = users;
      found_idx_next = MY_IDX;
    end
    if (!used && !tok_in.free_found) begin
      tok_next.free_found = 1'b1;
      free_idx_next       = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out       <= '0;
      found_idx_out <= '0;
      free_idx_out  <= '0;
    end else begin
      tok_out       <= tok_next;
      found_idx_out <= found_idx_next;
      free_idx_out  <= free_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (wr_hit) begin
      used <= wr.used;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      key   <= wr.key;
      count <= wr.count;
      users <= wr.users;
    end
  end

endmodule

[hdl/named_counting_semaphore_table.sv]
`timescale 1ns / 1ps
// Table of named counting semaphores.
// Request channel (req_valid, req_stall, req): action, 64-bit name key and an
// initial value that open uses when it creates a slot. Response channel
// (rsp_valid, rsp_stall, rsp): status, block and wake flags and the value.
// Each slot lives in one cell of a row of SEM_SLOTS cells. A request becomes
// a search token that moves one cell per cycle, picking up the matching slot
// and the lowest free slot; a single update then writes the chosen cell if
// the request succeeds, and registers the response. One request is in flight
// at a time, so a new request waits until the update of the last one, and
// the length of the cell row sets the request rate.
// The response register parts the two channels: a new request is taken while
// an earlier response waits. If the receiver stalls, the response holds and a
// finished search waits at the end of the row until the register frees.
// Reset empties every slot at once and clears all handshake state.
module named_counting_semaphore_table #(
  parameter int SEM_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  nsem_pkg::nsem_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output nsem_pkg::nsem_rsp_t rsp
);
  import nsem_pkg::*;

  localparam int IDX_W = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_APPLY  = 3'b100
  } state_t;

  state_t state, state_next;

  nsem_tok_t        tok       [SEM_SLOTS+1];
  logic [IDX_W-1:0] found_idx [SEM_SLOTS+1];
  logic [IDX_W-1:0] free_idx  [SEM_SLOTS+1];

  nsem_tok_t        tail;
  logic [IDX_W-1:0] tail_found_idx;
  logic [IDX_W-1:0] tail_free_idx;

  nsem_wr_t         wr;
  logic [IDX_W-1:0] wr_idx;
  nsem_rsp_t        rsp_next;

  logic accept;
  logic apply;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign apply     = (state == S_APPLY) && (!rsp_valid || !rsp_stall);

  always_comb begin
    tok[0]             = '0;
    tok[0].valid       = accept;
    tok[0].action      = req.action;
    tok[0].key         = req.key;
    tok[0].start_value = req.start_value;
    found_idx[0]       = '0;
    free_idx[0]        = '0;
  end

  for (genvar i = 0; i < SEM_SLOTS; i++) begin : g_cell
    nsem_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .tok_in        (tok[i]),
      .found_idx_in  (found_idx[i]),
      .free_idx_in   (free_idx[i]),
      .tok_out       (tok[i+1]),
      .found_idx_out (found_idx[i+1]),
      .free_idx_out  (free_idx[i+1]),
      .wr            (wr),
      .wr_idx        (wr_idx)
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (tok[SEM_SLOTS].valid) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        if (apply) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_SEARCH) && tok[SEM_SLOTS].valid) begin
      tail           <= tok[SEM_SLOTS];
      tail_found_idx <= found_idx[SEM_SLOTS];
      tail_free_idx  <= free_idx[SEM_SLOTS];
    end
  end

  // Update: work out the slot write and the response from the finished search.
  always_comb begin
    wr       = '0;
    wr.key   = tail.key;
    wr.used  = 1'b1;
    wr.count = tail.count;
    wr.users = tail.users;
    wr_idx   = tail_found_idx;
    rsp_next = '0;
    rsp_next.status = ST_OK;
    if (tail.action == ACT_OPEN) begin
      if (tail.found) begin
        wr.en          = apply;
        wr.users       = (tail.users != USERS_MAX) ? tail.users + 8'd1 : tail.users;
        rsp_next.count = tail.count;
      end else if (tail.free_found) begin
        wr.en          = apply;
        wr_idx         = tail_free_idx;
        wr.count       = signed'({1'b0, tail.start_value});
        wr.users       = 8'd1;
        rsp_next.count = signed'({1'b0, tail.start_value});
      end else begin
        rsp_next.status = ST_FULL;
      end
    end else if (!tail.found) begin
      rsp_next.status = ST_NOT_FOUND;
    end else begin
      wr.en = apply;
      case (tail.action)
        ACT_CLOSE: begin
          wr.users       = (tail.users != 8'd0) ? tail.users - 8'd1 : tail.users;
          wr.used        = (wr.users != 8'd0);
          rsp_next.count = tail.count;
        end
        ACT_WAIT: begin
          rsp_next.block = (tail.count <= 16'sd0);
          wr.count       = (tail.count != COUNT_MIN) ? tail.count - 16'sd1 : tail.count;
          rsp_next.count = wr.count;
        end
        ACT_POST: begin
          rsp_next.wake  = (tail.count < 16'sd0);
          wr.count       = (tail.count != COUNT_MAX) ? tail.count + 16'sd1 : tail.count;
          rsp_next.count = wr.count;
        end
        default: begin
          wr.en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (apply) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      rsp <= rsp_next;
    end
  end

endmodule

[hdl/nsem_checker.sv]
`timescale 1ns / 1ps

module nsem_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input nsem_pkg::nsem_req_t req,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input nsem_pkg::nsem_rsp_t rsp
);
  import nsem_pkg::*;

  // A response that is stalled stays put until its transfer.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // Only one request is in flight, so a transfer is followed by a stall.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while another is in flight");

  // Failed requests report no flags and a zero value.
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> !rsp.block && !rsp.wake && (rsp.count == 16'sd0))
    else $error("failed request carries flags or a value");

  // A wait that blocks never also wakes, and leaves the value negative.
  a_block_neg: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.block |-> !rsp.wake && (rsp.count < 16'sd0))
    else $error("blocking wait with inconsistent result");

  // A post that wakes a waiter leaves the value at or below zero.
  a_wake_nonpos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.wake |-> (rsp.count <= 16'sd0))
    else $error("wake with positive value");

endmodule

bind named_counting_semaphore_table nsem_checker u_nsem_checker (.*);
